// ===== src/i2cm_pkg.sv =====
// Package for the I2C master byte engine: action codes, widths, payload structs.
// No dependencies; used by the interfaces and all modules.
`timescale 1ns / 1ps

package i2cm_pkg;

  localparam int unsigned TICK_W  = 16;
  localparam int unsigned STEP_W  = 5;
  localparam int unsigned BITC_W  = 4;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned ACT_W   = 2;

  localparam logic [TICK_W-1:0] PHASE_TICKS_RST = TICK_W'(10);
  localparam logic [BYTE_W-1:0] BYTE_MSB        = 8'h80;

  typedef enum logic [ACT_W-1:0] {
    ACT_START = 2'd0,
    ACT_STOP  = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef struct packed {
    logic              cmd_valid;
    logic [ACT_W-1:0]  action;
    logic [BYTE_W-1:0] write_data;
    logic              sda_in;
  } cmd_t;

  typedef struct packed {
    logic              scl;
    logic              sda_out;
    logic              sda_drive;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] read_data;
  } res_t;

  // Bus phase decoder inputs: phase index, write sub-phase and current pin/shift state.
  typedef struct packed {
    action_t           action;
    logic [STEP_W-1:0] step;
    logic [1:0]        sub;
    logic              sda_in;
    logic [BYTE_W-1:0] shift;
    logic [BITC_W-1:0] bit_cnt;
    logic              scl;
    logic              sda;
    logic              sda_en;
    logic [BYTE_W-1:0] read_hold;
  } phase_in_t;

  typedef struct packed {
    logic              ok;
    logic [BYTE_W-1:0] shift;
    logic [BITC_W-1:0] bit_cnt;
    logic              scl;
    logic              sda;
    logic              sda_en;
    logic [BYTE_W-1:0] read_hold;
  } phase_out_t;

endpackage

// ===== src/i2cm_if.sv =====
// Valid/ready channel interfaces for the command and result streams.
// Depends on i2cm_pkg for field widths.
`timescale 1ns / 1ps

interface i2cm_cmd_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd_valid;
  logic [i2cm_pkg::ACT_W-1:0]   action;
  logic [i2cm_pkg::BYTE_W-1:0]  write_data;
  logic                         sda_in;

  modport source (output valid, cmd_valid, action, write_data, sda_in, input ready);
  modport sink   (input valid, cmd_valid, action, write_data, sda_in, output ready);
endinterface

interface i2cm_res_if;
  logic                         valid;
  logic                         ready;
  logic                         scl;
  logic                         sda_out;
  logic                         sda_drive;
  logic                         busy_res;
  logic                         done_res;
  logic [i2cm_pkg::BYTE_W-1:0]  read_data;

  modport source (output valid, scl, sda_out, sda_drive, busy_res, done_res, read_data,
                  input ready);
  modport sink   (input valid, scl, sda_out, sda_drive, busy_res, done_res, read_data,
                  output ready);
endinterface

// ===== src/i2c_master_byte_engine_unit.sv =====
// I2C master byte engine top level: one command/sample transfer per tick in,
// one pin-level result transfer per tick out.
// Path: input register, single engine update, result register; 1 transfer per
// cycle throughput while out_res.ready does not stall the result register.
// Reset (synchronous, rst_n low): engine idle, SCL/SDA high and driven,
// phase_ticks = 10, read byte cleared, both channel stages empty.
`timescale 1ns / 1ps

module i2c_master_byte_engine_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  i2cm_cmd_if.sink                      in_cmd,
  i2cm_res_if.source                    out_res,
  input  logic                          cfg_we,
  input  logic [i2cm_pkg::TICK_W-1:0]   cfg_wdata
);

  logic           s1_valid;
  i2cm_pkg::cmd_t s1_cmd;
  logic           s1_take;

  i2cm_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_cmd   (in_cmd),
    .s1_valid (s1_valid),
    .s1_cmd   (s1_cmd),
    .s1_take  (s1_take)
  );

  i2cm_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_cmd    (s1_cmd),
    .s1_take   (s1_take),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_res   (out_res)
  );

endmodule

// ===== src/i2cm_in_stage.sv =====
// Input register stage: captures one command transfer per cycle while its held command is empty or taken.
// Depends on i2cm_pkg and i2cm_cmd_if.
`timescale 1ns / 1ps

module i2cm_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  i2cm_cmd_if.sink        in_cmd,
  output logic            s1_valid,
  output i2cm_pkg::cmd_t  s1_cmd,
  input  logic            s1_take
);

  logic           valid_r;
  logic           valid_nxt;
  i2cm_pkg::cmd_t cmd_r;
  logic           load;

  assign in_cmd.ready = !valid_r || s1_take;
  assign load         = in_cmd.valid && in_cmd.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (s1_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd_r.cmd_valid  <= in_cmd.cmd_valid;
      cmd_r.action     <= in_cmd.action;
      cmd_r.write_data <= in_cmd.write_data;
      cmd_r.sda_in     <= in_cmd.sda_in;
    end
  end

  assign s1_valid = valid_r;
  assign s1_cmd   = cmd_r;

endmodule

// ===== src/i2cm_phase.sv =====
// Bus phase decoder: pin and shift-register changes for one phase of a command.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps

module i2cm_phase (
  input  i2cm_pkg::phase_in_t  ph_in,
  output i2cm_pkg::phase_out_t ph_out
);

  logic [i2cm_pkg::STEP_W-1:0] s;

  assign s = ph_in.step;

  always_comb begin
    ph_out.ok        = 1'b1;
    ph_out.shift     = ph_in.shift;
    ph_out.bit_cnt   = ph_in.bit_cnt;
    ph_out.scl       = ph_in.scl;
    ph_out.sda       = ph_in.sda;
    ph_out.sda_en    = ph_in.sda_en;
    ph_out.read_hold = ph_in.read_hold;
    unique case (ph_in.action)
      i2cm_pkg::ACT_START: begin
        priority if (s == 5'd0) begin
          ph_out.scl = 1'b1;
        end else if (s == 5'd1) begin
          ph_out.sda = 1'b1; ph_out.sda_en = 1'b1;
        end else if (s == 5'd2) begin
          ph_out.sda = 1'b0; ph_out.sda_en = 1'b1;
        end else if (s == 5'd3) begin
          ph_out.scl = 1'b0;
        end else begin
          ph_out.ok = 1'b0;
        end
      end
      i2cm_pkg::ACT_STOP: begin
        priority if (s == 5'd0) begin
          ph_out.sda = 1'b0; ph_out.sda_en = 1'b1;
        end else if (s == 5'd1) begin
          ph_out.scl = 1'b1;
        end else if (s == 5'd2) begin
          ph_out.sda = 1'b1; ph_out.sda_en = 1'b1;
        end else begin
          ph_out.ok = 1'b0;
        end
      end
      i2cm_pkg::ACT_WRITE: begin
        priority if (s < 5'd24) begin
          priority if (ph_in.sub == 2'd0) begin
            ph_out.scl = 1'b0;
          end else if (ph_in.sub == 2'd1) begin
            ph_out.sda    = |(ph_in.shift & i2cm_pkg::BYTE_MSB);
            ph_out.sda_en = 1'b1;
          end else begin
            ph_out.scl     = 1'b1;
            ph_out.shift   = {ph_in.shift[i2cm_pkg::BYTE_W-2:0], 1'b0};
            ph_out.bit_cnt = ph_in.bit_cnt + 4'd1;
          end
        end else if (s == 5'd24) begin
          ph_out.scl = 1'b0;
        end else if (s == 5'd25) begin
          ph_out.sda = 1'b1; ph_out.sda_en = 1'b0;
        end else if (s == 5'd26) begin
          ph_out.scl = 1'b1;
        end else if (s == 5'd27) begin
          ph_out.scl = 1'b0;
        end else begin
          ph_out.ok = 1'b0;
        end
      end
      i2cm_pkg::ACT_READ: begin
        priority if (s == 5'd0) begin
          ph_out.sda     = 1'b1;
          ph_out.sda_en  = 1'b0;
          ph_out.scl     = 1'b0;
          ph_out.shift   = '0;
          ph_out.bit_cnt = '0;
        end else if (s < 5'd16) begin
          if (s[0]) begin
            ph_out.scl     = 1'b1;
            ph_out.shift   = {ph_in.shift[i2cm_pkg::BYTE_W-2:0], ph_in.sda_in};
            ph_out.bit_cnt = ph_in.bit_cnt + 4'd1;
            if (s == 5'd15) begin
              ph_out.read_hold = {ph_in.shift[i2cm_pkg::BYTE_W-2:0], ph_in.sda_in};
            end
          end else begin
            ph_out.scl = 1'b0;
          end
        end else if (s == 5'd16) begin
          ph_out.scl = 1'b0; ph_out.sda_en = 1'b1;
        end else if (s == 5'd17) begin
          ph_out.sda = 1'b0; ph_out.sda_en = 1'b1;
        end else if (s == 5'd18) begin
          ph_out.scl = 1'b1;
        end else if (s == 5'd19) begin
          ph_out.scl = 1'b0;
        end else begin
          ph_out.ok = 1'b0;
        end
      end
      default: begin
        ph_out.ok = 1'b0;
      end
    endcase
  end

endmodule

// ===== src/i2cm_engine.sv =====
// Engine state, phase timer and result register for the byte engine.
// Depends on i2cm_pkg, i2cm_res_if and i2cm_phase.
`timescale 1ns / 1ps

module i2cm_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          s1_valid,
  input  i2cm_pkg::cmd_t                s1_cmd,
  output logic                          s1_take,
  input  logic                          cfg_we,
  input  logic [i2cm_pkg::TICK_W-1:0]   cfg_wdata,
  i2cm_res_if.source                    out_res
);

  logic [i2cm_pkg::TICK_W-1:0] ticks_r;
  logic [i2cm_pkg::TICK_W-1:0] timer_r, timer_nxt;
  logic [i2cm_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [1:0]                  sub_r, sub_nxt;
  logic [i2cm_pkg::BITC_W-1:0] bitc_r, bitc_nxt;
  logic [i2cm_pkg::BYTE_W-1:0] shift_r, shift_nxt;
  i2cm_pkg::action_t           act_r, act_nxt;
  logic                        active_r, active_nxt;
  logic                        scl_r, scl_nxt;
  logic                        sda_r, sda_nxt;
  logic                        sda_en_r, sda_en_nxt;
  logic [i2cm_pkg::BYTE_W-1:0] hold_r, hold_nxt;
  logic                        done_nxt;
  logic                        out_valid_r;
  i2cm_pkg::res_t              res_r;

  logic [i2cm_pkg::TICK_W-1:0] phase_len;
  logic [i2cm_pkg::TICK_W-1:0] timer_dec;
  logic [i2cm_pkg::STEP_W-1:0] step_inc;
  logic [1:0]                  sub_inc;
  logic                        start_cmd;
  i2cm_pkg::phase_in_t         ph_in;
  i2cm_pkg::phase_out_t        ph_out;

  assign s1_take   = s1_valid && (!out_valid_r || out_res.ready);
  assign phase_len = (ticks_r == '0) ? i2cm_pkg::TICK_W'(1) : ticks_r;
  assign timer_dec = timer_r - i2cm_pkg::TICK_W'(1);
  assign step_inc  = step_r + i2cm_pkg::STEP_W'(1);
  assign sub_inc   = (sub_r == 2'd2) ? 2'd0 : sub_r + 2'd1;
  assign start_cmd = !active_r && s1_cmd.cmd_valid;

  always_comb begin
    ph_in.sda_in    = s1_cmd.sda_in;
    ph_in.scl       = scl_r;
    ph_in.sda       = sda_r;
    ph_in.sda_en    = sda_en_r;
    ph_in.read_hold = hold_r;
    if (start_cmd) begin
      ph_in.action  = i2cm_pkg::action_t'(s1_cmd.action);
      ph_in.step    = '0;
      ph_in.sub     = 2'd0;
      ph_in.bit_cnt = '0;
      ph_in.shift   = (i2cm_pkg::action_t'(s1_cmd.action) == i2cm_pkg::ACT_WRITE) ?
                      s1_cmd.write_data : shift_r;
    end else begin
      ph_in.action  = act_r;
      ph_in.step    = step_inc;
      ph_in.sub     = sub_inc;
      ph_in.bit_cnt = bitc_r;
      ph_in.shift   = shift_r;
    end
  end

  i2cm_phase u_phase (
    .ph_in  (ph_in),
    .ph_out (ph_out)
  );

  always_comb begin
    timer_nxt  = timer_r;
    step_nxt   = step_r;
    sub_nxt    = sub_r;
    bitc_nxt   = bitc_r;
    shift_nxt  = shift_r;
    act_nxt    = act_r;
    active_nxt = active_r;
    scl_nxt    = scl_r;
    sda_nxt    = sda_r;
    sda_en_nxt = sda_en_r;
    hold_nxt   = hold_r;
    done_nxt   = 1'b0;
    if (!active_r) begin
      if (s1_cmd.cmd_valid) begin
        act_nxt    = i2cm_pkg::action_t'(s1_cmd.action);
        active_nxt = 1'b1;
        step_nxt   = '0;
        sub_nxt    = 2'd0;
        bitc_nxt   = ph_out.bit_cnt;
        shift_nxt  = ph_out.shift;
        scl_nxt    = ph_out.scl;
        sda_nxt    = ph_out.sda;
        sda_en_nxt = ph_out.sda_en;
        hold_nxt   = ph_out.read_hold;
        timer_nxt  = phase_len;
      end
    end else begin
      timer_nxt = timer_dec;
      if (timer_dec == '0) begin
        if (ph_out.ok) begin
          step_nxt   = step_inc;
          sub_nxt    = sub_inc;
          bitc_nxt   = ph_out.bit_cnt;
          shift_nxt  = ph_out.shift;
          scl_nxt    = ph_out.scl;
          sda_nxt    = ph_out.sda;
          sda_en_nxt = ph_out.sda_en;
          hold_nxt   = ph_out.read_hold;
          timer_nxt  = phase_len;
        end else begin
          active_nxt = 1'b0;
          step_nxt   = '0;
          done_nxt   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r     <= i2cm_pkg::PHASE_TICKS_RST;
      timer_r     <= '0;
      step_r      <= '0;
      sub_r       <= 2'd0;
      bitc_r      <= '0;
      shift_r     <= '0;
      act_r       <= i2cm_pkg::ACT_START;
      active_r    <= 1'b0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      sda_en_r    <= 1'b1;
      hold_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        ticks_r <= cfg_wdata;
      end
      if (s1_take) begin
        timer_r  <= timer_nxt;
        step_r   <= step_nxt;
        sub_r    <= sub_nxt;
        bitc_r   <= bitc_nxt;
        shift_r  <= shift_nxt;
        act_r    <= act_nxt;
        active_r <= active_nxt;
        scl_r    <= scl_nxt;
        sda_r    <= sda_nxt;
        sda_en_r <= sda_en_nxt;
        hold_r   <= hold_nxt;
      end
      if (s1_take) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      res_r.scl       <= scl_nxt;
      res_r.sda_out   <= sda_nxt;
      res_r.sda_drive <= sda_en_nxt;
      res_r.busy_res  <= active_nxt;
      res_r.done_res  <= done_nxt;
      res_r.read_data <= hold_nxt;
    end
  end

  assign out_res.valid     = out_valid_r;
  assign out_res.scl       = res_r.scl;
  assign out_res.sda_out   = res_r.sda_out;
  assign out_res.sda_drive = res_r.sda_drive;
  assign out_res.busy_res  = res_r.busy_res;
  assign out_res.done_res  = res_r.done_res;
  assign out_res.read_data = res_r.read_data;

endmodule
